// File: rtl/core/btnfa_pkg.sv
// Shared constants, types and helpers of the boundary-tag next-fit allocator.
package btnfa_pkg;

  localparam int MEM_WORDS   = 2048;
  localparam int AW          = $clog2(MEM_WORDS);
  localparam int WORD_W      = AW + 3;
  localparam int EXT_W       = AW + 2;
  localparam int SZ_W        = AW + 1;
  localparam int GUARD_W     = AW + 1;
  localparam int MIN_PAYLOAD = 3;
  localparam int WHOLE_SLACK = 5;
  localparam int HEAP_BASE   = 4;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_NO_FIT      = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_OUT,
    A_START, A_CHECK, A_SETPU, A_NEXT, A_WHOLE, A_SPMV, A_FIN,
    R_WALK, R_HDR, R_NXT, R_NH, R_CASE, R_C1MV, R_C2, R_CLRPU,
    R_C3A, R_C3B, R_C3C, R_AP0, R_AP1, R_AP2, R_AP3, R_AP4, R_FIN, R_BAD,
    MF_H, MF_F, LK_N, LK_P, LK_G, UL_1, UL_2, MV_1, MV_2, MV_3, MV_4
  } state_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [EXT_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } heap_req_t;

  // Heap contents after reset: sentinel, its links, and one big free block.
  function automatic logic [WORD_W-1:0] init_word(input logic [AW-1:0] a);
    logic [WORD_W-1:0] v;
    v = '0;
    if (a == AW'(0)) begin
      v = WORD_W'(1);
    end else if (a == AW'(1) || a == AW'(2)) begin
      v = WORD_W'(HEAP_BASE);
    end else if (a == AW'(HEAP_BASE)) begin
      v = WORD_W'((MEM_WORDS - HEAP_BASE) * 4 + 2);
    end else if (a == AW'(MEM_WORDS - 1)) begin
      v = WORD_W'(MEM_WORDS - HEAP_BASE);
    end
    return v;
  endfunction

endpackage

// File: rtl/core/btnfa_heap_ram.sv
// Heap word memory: one write and one registered read per cycle.
module btnfa_heap_ram
  import btnfa_pkg::*;
(
  input  logic              clk,
  input  heap_req_t         req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rd_word;
  logic              rd_ok;
  logic              in_range;

  // Addresses beyond the heap read as zero and drop writes.
  assign in_range = req.addr < EXT_W'(MEM_WORDS);

  always_ff @(posedge clk) begin
    if (req.we && in_range) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_word <= mem[req.addr[AW-1:0]];
      rd_ok   <= in_range;
    end
  end

  assign rdata = rd_ok ? rd_word : '0;

endmodule

// File: rtl/core/boundary_tag_next_fit_allocator.sv
// Top level of the boundary-tag next-fit heap allocator.
//
// The heap lives in a single 2048-word memory with a registered read port, and a
// sequencer reads, modifies and writes it, at most one access per cycle. After
// reset a clearing pass writes every heap word once before the block accepts
// its first transaction. An allocation walks the free list from the rover
// until it finds a fit, then unlinks a block taken whole or splits one. A
// release first walks the block headers from word 4 to check the address,
// then coalesces the block with its free neighbours. One transaction is worked
// on at a time; a finished result waits in the output register while the next
// request is taken.
module boundary_tag_next_fit_allocator
  import btnfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [10:0] request_size, [21:11] block_address, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  // [0] cmd
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] granted_address, [21:11] granted_words, [32:22] free_block_count,
  // [44:33] free_word_total, [55:45] used_block_count, [67:56] used_word_total,
  // [71:68] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  state_t state, state_next, ret;
  heap_req_t mreq;
  logic [WORD_W-1:0] rdata;

  // Counters and rover.
  logic [AW-1:0]   rover;
  logic [AW-1:0]   fb, ub;
  logic [SZ_W-1:0] fw, uw;

  // Transaction context.
  logic [AW-1:0]   req_r, blk, cur, start, ln, lp, clr;
  logic [GUARD_W-1:0] guard;
  logic [SZ_W-1:0] asz, sz, ms_s;
  logic            whole_r, lk_move, case4;
  logic [EXT_W-1:0] bsplit, walk_p, nxt, ms_a, mx, my, pa;
  logic [WORD_W-1:0] h, nh;

  // Result register.
  status_t         res_status;
  logic [AW-1:0]   res_addr, res_words;

  logic [SZ_W-1:0]  fsz, need, nsz;
  logic             fit, whole_fit, at_end, walk_go, nofit_exit;
  logic             prev_used, next_used;
  logic [GUARD_W-1:0] guard_inc;
  logic [EXT_W-1:0] fit_end;
  logic             in_acc, out_free;

  btnfa_heap_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign fsz        = rdata[WORD_W-1:2];
  assign need       = SZ_W'(req_r) + SZ_W'(1);
  assign fit        = fsz >= need;
  assign whole_fit  = fsz <= SZ_W'(req_r) + SZ_W'(WHOLE_SLACK);
  assign fit_end    = EXT_W'(cur) + EXT_W'(fsz);
  assign guard_inc  = guard + GUARD_W'(1);
  assign nofit_exit = (rdata[AW-1:0] == start) || (guard_inc == GUARD_W'(MEM_WORDS + 1));
  assign at_end     = nxt >= EXT_W'(MEM_WORDS);
  assign walk_go    = (walk_p < EXT_W'(MEM_WORDS)) && (walk_p <= EXT_W'(blk));
  assign nsz        = nh[WORD_W-1:2];
  assign prev_used  = h[1];
  assign next_used  = nh[0];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the memory access of each step.
  always_comb begin
    state_next = state;
    mreq       = '0;
    unique case (state)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(clr);
        mreq.wdata = init_word(clr);
        if (clr == AW'(MEM_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_next = (s_axis_tuser[0] == CMD_RELEASE) ? R_WALK : A_START;
        end
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      A_START: begin
        mreq.re   = 1'b1;
        mreq.addr = EXT_W'(rover);
        state_next = A_CHECK;
      end
      A_CHECK: begin
        if (fit && whole_fit) begin
          if (fit_end < EXT_W'(MEM_WORDS)) begin
            mreq.re   = 1'b1;
            mreq.addr = fit_end;
            state_next = A_SETPU;
          end else begin
            state_next = A_WHOLE;
          end
        end else if (fit) begin
          state_next = MF_H;
        end else begin
          mreq.re   = 1'b1;
          mreq.addr = EXT_W'(cur) + EXT_W'(1);
          state_next = A_NEXT;
        end
      end
      A_SETPU: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(cur) + EXT_W'(asz);
        mreq.wdata = rdata | WORD_W'(2);
        state_next = A_WHOLE;
      end
      A_NEXT: begin
        if (nofit_exit) begin
          state_next = S_OUT;
        end else begin
          mreq.re   = 1'b1;
          mreq.addr = EXT_W'(rdata[AW-1:0]);
          state_next = A_CHECK;
        end
      end
      A_WHOLE: state_next = LK_N;
      A_SPMV:  state_next = LK_N;
      A_FIN: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(cur);
        mreq.wdata = {asz, 2'b11};
        state_next = S_OUT;
      end
      R_WALK: begin
        if (walk_go) begin
          mreq.re   = 1'b1;
          mreq.addr = walk_p;
          state_next = R_HDR;
        end else begin
          state_next = R_BAD;
        end
      end
      R_HDR: begin
        if (walk_p == EXT_W'(blk)) begin
          state_next = rdata[0] ? R_NXT : R_BAD;
        end else if (fsz == '0) begin
          state_next = R_BAD;
        end else begin
          state_next = R_WALK;
        end
      end
      R_NXT: begin
        mreq.re   = 1'b1;
        mreq.addr = nxt;
        state_next = R_NH;
      end
      R_NH: state_next = R_CASE;
      R_CASE: begin
        if (prev_used && !next_used) begin
          state_next = MF_H;
        end else if (!prev_used && next_used) begin
          mreq.re   = 1'b1;
          mreq.addr = EXT_W'(blk) - EXT_W'(1);
          state_next = R_C2;
        end else if (!prev_used && !next_used) begin
          state_next = LK_N;
        end else begin
          state_next = MF_H;
        end
      end
      R_C1MV: state_next = LK_N;
      R_C2:   state_next = MF_H;
      R_CLRPU: begin
        if (!at_end) begin
          mreq.we    = 1'b1;
          mreq.addr  = nxt;
          mreq.wdata = nh & ~WORD_W'(2);
        end
        state_next = case4 ? R_AP0 : R_FIN;
      end
      R_C3A: begin
        mreq.re   = 1'b1;
        mreq.addr = EXT_W'(blk) - EXT_W'(1);
        state_next = R_C3B;
      end
      R_C3B: begin
        mreq.re   = 1'b1;
        mreq.addr = EXT_W'(blk) - EXT_W'(rdata);
        state_next = R_C3C;
      end
      R_C3C: state_next = MF_H;
      R_AP0: begin
        mreq.re   = 1'b1;
        mreq.addr = EXT_W'(2);
        state_next = R_AP1;
      end
      R_AP1: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(blk) + EXT_W'(1);
        mreq.wdata = '0;
        state_next = R_AP2;
      end
      R_AP2: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(blk) + EXT_W'(2);
        mreq.wdata = WORD_W'(lp);
        state_next = R_AP3;
      end
      R_AP3: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(lp) + EXT_W'(1);
        mreq.wdata = WORD_W'(blk);
        state_next = R_AP4;
      end
      R_AP4: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(2);
        mreq.wdata = WORD_W'(blk);
        state_next = R_FIN;
      end
      R_FIN: state_next = S_OUT;
      R_BAD: state_next = S_OUT;
      MF_H: begin
        mreq.we    = 1'b1;
        mreq.addr  = ms_a;
        mreq.wdata = {ms_s, 2'b10};
        state_next = MF_F;
      end
      MF_F: begin
        mreq.we    = 1'b1;
        mreq.addr  = ms_a + EXT_W'(ms_s) - EXT_W'(1);
        mreq.wdata = WORD_W'(ms_s);
        state_next = ret;
      end
      LK_N: begin
        mreq.re   = 1'b1;
        mreq.addr = mx + EXT_W'(1);
        state_next = LK_P;
      end
      LK_P: begin
        mreq.re   = 1'b1;
        mreq.addr = mx + EXT_W'(2);
        state_next = LK_G;
      end
      LK_G: state_next = lk_move ? MV_1 : UL_1;
      UL_1: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(ln) + EXT_W'(2);
        mreq.wdata = WORD_W'(lp);
        state_next = UL_2;
      end
      UL_2: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(lp) + EXT_W'(1);
        mreq.wdata = WORD_W'(ln);
        state_next = ret;
      end
      MV_1: begin
        mreq.we    = 1'b1;
        mreq.addr  = my + EXT_W'(1);
        mreq.wdata = WORD_W'(ln);
        state_next = MV_2;
      end
      MV_2: begin
        mreq.we    = 1'b1;
        mreq.addr  = my + EXT_W'(2);
        mreq.wdata = WORD_W'(lp);
        state_next = MV_3;
      end
      MV_3: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(ln) + EXT_W'(2);
        mreq.wdata = WORD_W'(my);
        state_next = MV_4;
      end
      MV_4: begin
        mreq.we    = 1'b1;
        mreq.addr  = EXT_W'(lp) + EXT_W'(1);
        mreq.wdata = WORD_W'(my);
        state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr           <= '0;
      rover         <= '0;
      fb            <= AW'(1);
      fw            <= SZ_W'(MEM_WORDS - HEAP_BASE);
      ub            <= '0;
      uw            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == A_FIN) begin
        rover <= whole_r ? ln : bsplit[AW-1:0];
        ub    <= ub + AW'(1);
        fw    <= fw - asz;
        uw    <= uw + asz;
      end
      if (state == R_CASE && next_used == 1'b0 && nxt == EXT_W'(rover)) rover <= '0;
      if (state == UL_2) fb <= fb - AW'(1);
      if (state == R_AP4) fb <= fb + AW'(1);
      if (state == R_FIN) begin
        fw <= fw + sz;
        uw <= uw - sz;
        ub <= ub - AW'(1);
      end
    end
  end

  // Transaction context, sequencer operands and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          req_r  <= (s_axis_tdata[AW-1:0] < AW'(MIN_PAYLOAD)) ?
                    AW'(MIN_PAYLOAD) : s_axis_tdata[AW-1:0];
          blk    <= s_axis_tdata[2*AW-1:AW];
          walk_p <= EXT_W'(HEAP_BASE);
        end
      end
      A_START: begin
        cur   <= rover;
        start <= rover;
        guard <= '0;
      end
      A_CHECK: begin
        whole_r <= whole_fit;
        asz     <= whole_fit ? fsz : need;
        bsplit  <= EXT_W'(cur) + EXT_W'(need);
        ms_a    <= EXT_W'(cur) + EXT_W'(need);
        ms_s    <= fsz - need;
        ret     <= A_SPMV;
      end
      A_NEXT: begin
        cur   <= rdata[AW-1:0];
        guard <= guard_inc;
        if (nofit_exit) begin
          res_status <= ST_NO_FIT;
          res_addr   <= '0;
          res_words  <= '0;
        end
      end
      A_WHOLE: begin
        mx      <= EXT_W'(cur);
        lk_move <= 1'b0;
        ret     <= A_FIN;
      end
      A_SPMV: begin
        mx      <= EXT_W'(cur);
        my      <= bsplit;
        lk_move <= 1'b1;
        ret     <= A_FIN;
      end
      A_FIN: begin
        res_status <= ST_DONE;
        res_addr   <= cur;
        res_words  <= asz[AW-1:0];
      end
      R_HDR: begin
        h      <= rdata;
        sz     <= fsz;
        nxt    <= EXT_W'(blk) + EXT_W'(fsz);
        walk_p <= walk_p + EXT_W'(fsz);
      end
      R_NH: nh <= at_end ? WORD_W'(1) : rdata;
      R_CASE: begin
        case4 <= prev_used && next_used;
        if (prev_used && !next_used) begin
          ms_a <= EXT_W'(blk);
          ms_s <= sz + nsz;
          ret  <= R_C1MV;
        end else if (!prev_used && !next_used) begin
          mx      <= nxt;
          lk_move <= 1'b0;
          ret     <= R_C3A;
        end else begin
          ms_a <= EXT_W'(blk);
          ms_s <= sz;
          ret  <= R_CLRPU;
        end
      end
      R_C1MV: begin
        mx      <= nxt;
        my      <= EXT_W'(blk);
        lk_move <= 1'b1;
        ret     <= R_FIN;
      end
      R_C2: begin
        ms_a <= EXT_W'(blk) - EXT_W'(rdata);
        ms_s <= SZ_W'(rdata) + sz;
        ret  <= R_CLRPU;
      end
      R_C3B: pa <= EXT_W'(blk) - EXT_W'(rdata);
      R_C3C: begin
        ms_a <= pa;
        ms_s <= fsz + sz + nsz;
        ret  <= R_FIN;
      end
      R_AP1: lp <= rdata[AW-1:0];
      R_FIN: begin
        res_status <= ST_DONE;
        res_addr   <= '0;
        res_words  <= sz[AW-1:0];
      end
      R_BAD: begin
        res_status <= ST_BAD_RELEASE;
        res_addr   <= '0;
        res_words  <= '0;
      end
      LK_P: ln <= rdata[AW-1:0];
      LK_G: lp <= rdata[AW-1:0];
      S_OUT: begin
        if (out_free) begin
          m_axis_tuser <= res_status;
          m_axis_tdata <= {4'b0000, uw, ub, fw, fb, res_words, res_addr};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The sequencer never reads and writes the heap in the same cycle.
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mreq.we && mreq.re))
    else $error("heap read and write issued together");

  // Words move between the free and used totals, never appear or vanish.
  a_word_balance: assert property (@(posedge clk) disable iff (rst)
    (fw + uw) == SZ_W'(MEM_WORDS - HEAP_BASE))
    else $error("free and used word totals out of balance");

  // Nothing touches the heap while waiting for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mreq.we && !mreq.re))
    else $error("heap access while idle");

  // A completed allocation adds exactly one used block.
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == A_FIN) |=> (ub == $past(ub) + AW'(1)))
    else $error("used block count not advanced by allocation");
`endif

endmodule
